// ===== hw/rtl/mwm_pkg.sv =====
// Shared types and constants for the mecanum wheel mixer.
package mwm_pkg;

   localparam int AXIS_W      = 8;
   localparam int SUM_W       = 10;
   localparam int MAG_W       = 9;
   localparam int SPEED_W     = 8;
   localparam int PROD_W      = MAG_W + SPEED_W;
   localparam int QUO_W       = 8;
   localparam int WHEEL_W     = 9;
   localparam int NUM_WHEELS  = 4;
   localparam int NUM_AXES    = 3;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [MAG_W-1:0]   MIN_DIVISOR     = 9'd127;
   localparam logic [AXIS_W-1:0]  DEADBAND_RESET  = 8'd20;
   localparam logic [SPEED_W-1:0] MAX_SPEED_RESET = 8'd255;

   // wheel order in the entry and on the result ports
   localparam int WHEEL_LF = 0;
   localparam int WHEEL_LB = 1;
   localparam int WHEEL_RF = 2;
   localparam int WHEEL_RB = 3;

   // register indexes of the configuration port
   localparam logic CSR_DEADBAND  = 1'b0;
   localparam logic CSR_MAX_SPEED = 1'b1;

   // one classified sample: wheel sum magnitudes, their signs, common divisor
   typedef struct packed {
      logic [NUM_WHEELS-1:0][MAG_W-1:0] mag;
      logic [NUM_WHEELS-1:0]            neg;
      logic [MAG_W-1:0]                 divisor;
   } mwm_entry_type;

endpackage

// ===== hw/rtl/mecanum_wheel_mixer.sv =====
// Top level of the mecanum wheel mixer: config registers, front end, queue, divide pipeline.

// Takes one stick sample beat per clock while req_stall is low and returns one
// beat of four signed wheel speeds per sample, in order. A sample is written into
// the queue; the speed multiply is formed from the queue head into stage 0 of the
// divide pipeline, and the restoring divide then resolves one quotient bit in each
// later stage and the last one in the result register, for all four wheels at once.
// A stalled result holds the whole divide pipeline; the queue then takes up to
// QUEUE_DEPTH more samples before req_stall rises. Register writes are always
// ready and must only be issued while no sample is in flight.
module mecanum_wheel_mixer #(
   parameter int QUEUE_DEPTH = mwm_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_strafe_raw,
   input  logic [7:0]        req_drive_raw,
   input  logic [7:0]        req_turn_raw,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [8:0] rsp_left_front,
   output logic signed [8:0] rsp_left_back,
   output logic signed [8:0] rsp_right_front,
   output logic signed [8:0] rsp_right_back,

   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [7:0]        csr_data
);
   import mwm_pkg::*;

   logic [AXIS_W-1:0]  deadband_ff, deadband_in;
   logic [SPEED_W-1:0] max_speed_ff, max_speed_in;

   mwm_entry_type front_entry;
   mwm_entry_type head_entry;
   logic          queue_full;
   logic          queue_not_empty;
   logic          queue_pop;
   logic          req_beat;

   assign csr_ready = 1'b1;

   always_comb begin
      deadband_in  = deadband_ff;
      max_speed_in = max_speed_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEADBAND:  deadband_in  = csr_data;
            CSR_MAX_SPEED: max_speed_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff  <= DEADBAND_RESET;
         max_speed_ff <= MAX_SPEED_RESET;
      end else begin
         deadband_ff  <= deadband_in;
         max_speed_ff <= max_speed_in;
      end
   end

   assign req_stall = queue_full;
   assign req_beat  = req_valid && !req_stall;

   mwm_front u_front (
      .strafe_raw (req_strafe_raw),
      .drive_raw  (req_drive_raw),
      .turn_raw   (req_turn_raw),
      .deadband   (deadband_ff),
      .entry      (front_entry)
   );

   mwm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_beat),
      .push_entry (front_entry),
      .pop        (queue_pop),
      .not_empty  (queue_not_empty),
      .head_entry (head_entry),
      .full       (queue_full)
   );

   mwm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (queue_not_empty),
      .in_entry        (head_entry),
      .max_speed       (max_speed_ff),
      .pop             (queue_pop),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_left_front  (rsp_left_front),
      .rsp_left_back   (rsp_left_back),
      .rsp_right_front (rsp_right_front),
      .rsp_right_back  (rsp_right_back)
   );

endmodule

// ===== hw/rtl/mwm_front.sv =====
// Front end: centers stick bytes, applies the deadband, forms wheel sums and divisor.
module mwm_front (
   input  logic [7:0]             strafe_raw,
   input  logic [7:0]             drive_raw,
   input  logic [7:0]             turn_raw,
   input  logic [7:0]             deadband,
   output mwm_pkg::mwm_entry_type entry
);
   import mwm_pkg::*;

   logic [AXIS_W-1:0]        raw [NUM_AXES];
   logic signed [AXIS_W-1:0] cen [NUM_AXES];
   logic [AXIS_W-1:0]        mag [NUM_AXES];
   logic signed [SUM_W-1:0]  ax  [NUM_AXES];
   logic signed [SUM_W-1:0]  sum [NUM_WHEELS];
   logic [MAG_W-1:0]         dmax;

   assign raw[0] = strafe_raw;
   assign raw[1] = drive_raw;
   assign raw[2] = turn_raw;

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         // raw - 128 is the byte with its top bit flipped
         cen[i] = {~raw[i][AXIS_W-1], raw[i][AXIS_W-2:0]};
         mag[i] = cen[i][AXIS_W-1] ? AXIS_W'(-cen[i]) : AXIS_W'(cen[i]);
         ax[i]  = (mag[i] < deadband) ? '0 : SUM_W'(cen[i]);
      end

      sum[WHEEL_LF] =  ax[0] + ax[1] + ax[2];
      sum[WHEEL_LB] = -ax[0] + ax[1] + ax[2];
      sum[WHEEL_RF] = -ax[0] + ax[1] - ax[2];
      sum[WHEEL_RB] =  ax[0] + ax[1] - ax[2];

      dmax = MIN_DIVISOR;
      for (int w = 0; w < NUM_WHEELS; w++) begin
         entry.neg[w] = sum[w][SUM_W-1];
         entry.mag[w] = sum[w][SUM_W-1] ? MAG_W'(-sum[w]) : MAG_W'(sum[w]);
         if (entry.mag[w] > dmax) begin
            dmax = entry.mag[w];
         end
      end
      entry.divisor = dmax;
   end

endmodule

// ===== hw/rtl/mwm_queue.sv =====
// Small FIFO between the front end and the divide pipeline.
module mwm_queue #(
   parameter int DEPTH = mwm_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mwm_pkg::mwm_entry_type push_entry,
   input  logic                   pop,
   output logic                   not_empty,
   output mwm_pkg::mwm_entry_type head_entry,
   output logic                   full
);
   import mwm_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   mwm_entry_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign not_empty  = (count_ff != '0);
   assign full       = (count_ff == FULL_CNT);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hw/rtl/mwm_back.sv =====
// Back end: scales each wheel sum by max speed and divides, one quotient bit per stage.
module mwm_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  mwm_pkg::mwm_entry_type        in_entry,
   input  logic [7:0]                    max_speed,
   output logic                          pop,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic signed [8:0]             rsp_left_front,
   output logic signed [8:0]             rsp_left_back,
   output logic signed [8:0]             rsp_right_front,
   output logic signed [8:0]             rsp_right_back
);
   import mwm_pkg::*;

   // stage 0 holds the product, stage s holds quotient bits above bit QUO_W-1-s
   localparam int STAGES = QUO_W;

   logic                   valid_ff [STAGES], valid_in [STAGES];
   logic [MAG_W-1:0]       div_ff   [STAGES], div_in   [STAGES];
   logic [NUM_WHEELS-1:0]  neg_ff   [STAGES], neg_in   [STAGES];
   logic [PROD_W-1:0]      rem_ff   [STAGES][NUM_WHEELS];
   logic [PROD_W-1:0]      rem_in   [STAGES][NUM_WHEELS];
   logic [QUO_W-1:0]       quo_ff   [STAGES][NUM_WHEELS];
   logic [QUO_W-1:0]       quo_in   [STAGES][NUM_WHEELS];

   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [WHEEL_W-1:0] wheel_ff [NUM_WHEELS], wheel_in [NUM_WHEELS];

   logic [PROD_W-1:0]      trial    [STAGES][NUM_WHEELS];
   logic [QUO_W-1:0]       last_quo [NUM_WHEELS];
   logic                   advance;

   // the whole pipe moves together unless the result register is held
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = advance && in_valid;

   always_comb begin
      valid_in[0] = in_valid;
      div_in[0]   = in_entry.divisor;
      neg_in[0]   = in_entry.neg;
      for (int w = 0; w < NUM_WHEELS; w++) begin
         rem_in[0][w] = PROD_W'(in_entry.mag[w]) * PROD_W'(max_speed);
         quo_in[0][w] = '0;
      end

      for (int s = 1; s < STAGES; s++) begin
         valid_in[s] = valid_ff[s-1];
         div_in[s]   = div_ff[s-1];
         neg_in[s]   = neg_ff[s-1];
         for (int w = 0; w < NUM_WHEELS; w++) begin
            trial[s][w]  = PROD_W'(div_ff[s-1]) << (QUO_W - s);
            rem_in[s][w] = rem_ff[s-1][w];
            quo_in[s][w] = quo_ff[s-1][w];
            if (rem_ff[s-1][w] >= trial[s][w]) begin
               rem_in[s][w]            = rem_ff[s-1][w] - trial[s][w];
               quo_in[s][w][QUO_W - s] = 1'b1;
            end
         end
      end
      for (int w = 0; w < NUM_WHEELS; w++) begin
         trial[0][w] = '0;
      end

      // final bit, then sign; magnitude is truncated so this rounds toward zero
      rsp_valid_in = valid_ff[STAGES-1];
      for (int w = 0; w < NUM_WHEELS; w++) begin
         last_quo[w] = quo_ff[STAGES-1][w];
         if (rem_ff[STAGES-1][w] >= PROD_W'(div_ff[STAGES-1])) begin
            last_quo[w][0] = 1'b1;
         end
         wheel_in[w] = neg_ff[STAGES-1][w] ? -WHEEL_W'(last_quo[w])
                                           :  WHEEL_W'(last_quo[w]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         for (int s = 0; s < STAGES; s++) begin
            valid_ff[s] <= valid_in[s];
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < STAGES; s++) begin
            div_ff[s] <= div_in[s];
            neg_ff[s] <= neg_in[s];
            for (int w = 0; w < NUM_WHEELS; w++) begin
               rem_ff[s][w] <= rem_in[s][w];
               quo_ff[s][w] <= quo_in[s][w];
            end
         end
         for (int w = 0; w < NUM_WHEELS; w++) begin
            wheel_ff[w] <= wheel_in[w];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_front  = wheel_ff[WHEEL_LF];
   assign rsp_left_back   = wheel_ff[WHEEL_LB];
   assign rsp_right_front = wheel_ff[WHEEL_RF];
   assign rsp_right_back  = wheel_ff[WHEEL_RB];

endmodule

// ===== verif/mecanum_wheel_mixer_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the mecanum wheel mixer: directed table, then random phases.
module mecanum_wheel_mixer_test;
   import mwm_pkg::*;

   localparam int AXIS_CENTRE    = 128;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 60;
   localparam int DRAIN_CYCLES   = 20;
   localparam int NUM_DIRECTED   = 16;
   localparam int NUM_PHASES     = 9;
   localparam int PHASE_ITEMS    = 170;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic signed [8:0] lf;
      logic signed [8:0] lb;
      logic signed [8:0] rf;
      logic signed [8:0] rb;
   } wheel_set_type;

   typedef struct packed {
      logic [7:0]    strafe;
      logic [7:0]    drive;
      logic [7:0]    turn;
      logic          typed;
      wheel_set_type want;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [7:0]        req_strafe_raw = 8'd128;
   logic [7:0]        req_drive_raw = 8'd128;
   logic [7:0]        req_turn_raw = 8'd128;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic signed [8:0] rsp_left_front;
   logic signed [8:0] rsp_left_back;
   logic signed [8:0] rsp_right_front;
   logic signed [8:0] rsp_right_back;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_index = CSR_DEADBAND;
   logic [7:0]        csr_data = 8'd0;

   // shadow copies of the block's registers
   logic [7:0] zone_setting = DEADBAND_RESET;
   logic [7:0] speed_setting = MAX_SPEED_RESET;

   wheel_set_type pending_speeds[$];
   stim_row_type  directed_rows [NUM_DIRECTED];
   logic [7:0] phase_zone  [NUM_PHASES] = '{0, 128, 129, 0, 255, 5, 64, 1, 20};
   logic [7:0] phase_speed [NUM_PHASES] = '{255, 255, 1, 0, 255, 127, 200, 128, 255};

   int fault_count = 0;
   int stall_left = 0;
   int quiet_cycles = 0;
   bit hold_request = 1'b0;
   bit calm = 1'b0;

   mecanum_wheel_mixer u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_strafe_raw  (req_strafe_raw),
      .req_drive_raw   (req_drive_raw),
      .req_turn_raw    (req_turn_raw),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_left_front  (rsp_left_front),
      .rsp_left_back   (rsp_left_back),
      .rsp_right_front (rsp_right_front),
      .rsp_right_back  (rsp_right_back),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int centred_axis(input logic [7:0] raw);
      int v;
      v = int'(raw) - AXIS_CENTRE;
      if ((v < 0 ? -v : v) < int'(zone_setting)) v = 0;
      return v;
   endfunction

   function automatic wheel_set_type mix_wheels(input logic [7:0] strafe, drive, turn);
      int x, y, r, divisor, mag;
      int sums [4];
      wheel_set_type speeds;
      x = centred_axis(strafe);
      y = centred_axis(drive);
      r = centred_axis(turn);
      sums[0] = x + y + r;
      sums[1] = -x + y + r;
      sums[2] = -x + y - r;
      sums[3] = x + y - r;
      divisor = int'(MIN_DIVISOR);
      foreach (sums[i]) begin
         mag = sums[i] < 0 ? -sums[i] : sums[i];
         if (mag > divisor) divisor = mag;
      end
      // signed int division truncates toward zero
      speeds.lf = 9'(sums[0] * int'(speed_setting) / divisor);
      speeds.lb = 9'(sums[1] * int'(speed_setting) / divisor);
      speeds.rf = 9'(sums[2] * int'(speed_setting) / divisor);
      speeds.rb = 9'(sums[3] * int'(speed_setting) / divisor);
      return speeds;
   endfunction

   // mix of full range, corners, near center and around the deadband edge
   function automatic logic [7:0] rand_axis();
      int m;
      case ($urandom_range(3))
         0: return 8'($urandom_range(255));
         1: begin
            case ($urandom_range(6))
               0: return 8'd0;
               1: return 8'd1;
               2: return 8'd127;
               3: return 8'd128;
               4: return 8'd129;
               5: return 8'd254;
               default: return 8'd255;
            endcase
         end
         2: return 8'($urandom_range(148, 108));
         default: begin
            m = int'(zone_setting) + int'($urandom_range(2)) - 1;
            if (m < 0) m = 0;
            if (m > 128) m = 128;
            if ($urandom_range(1) == 1) return 8'((m > 127) ? 255 : AXIS_CENTRE + m);
            return 8'(AXIS_CENTRE - m);
         end
      endcase
   endfunction

   task automatic offer_sample(input stim_row_type row);
      int gap;
      if (!calm && $urandom_range(5) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(6, 1);
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_strafe_raw <= row.strafe;
      req_drive_raw  <= row.drive;
      req_turn_raw   <= row.turn;
      do @(posedge clock); while (req_stall);
      pending_speeds.push_back(row.typed ? row.want
                                         : mix_wheels(row.strafe, row.drive, row.turn));
   endtask

   task automatic wait_drained();
      while (pending_speeds.size() != 0) @(posedge clock);
   endtask

   // both registers go in back to back; valid stays up across the two beats
   task automatic set_config(input logic [7:0] zone, speed);
      csr_valid <= 1'b1;
      csr_index <= CSR_DEADBAND;
      csr_data  <= zone;
      do @(posedge clock); while (!csr_ready);
      zone_setting = zone;
      csr_index <= CSR_MAX_SPEED;
      csr_data  <= speed;
      do @(posedge clock); while (!csr_ready);
      speed_setting = speed;
      csr_valid <= 1'b0;
   endtask

   task automatic note_fault(input string msg);
      fault_count++;
      if (fault_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
   endtask

   task automatic check_wheel(input string name, input logic signed [8:0] want, got);
      if (got !== want)
         note_fault($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
   endtask

   // result side: random stall bursts, plus one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && !calm && $urandom_range(7) == 0) begin
            stall_left = $urandom_range(6, 1);
         end
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   always @(posedge clock) begin
      wheel_set_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_left_front, rsp_left_back, rsp_right_front, rsp_right_back};
         if (pending_speeds.size() == 0) begin
            note_fault($sformatf("unexpected result beat %0d %0d %0d %0d",
                                 got.lf, got.lb, got.rf, got.rb));
         end else begin
            want = pending_speeds.pop_front();
            check_wheel("left_front", want.lf, got.lf);
            check_wheel("left_back", want.lb, got.lb);
            check_wheel("right_front", want.rf, got.rf);
            check_wheel("right_back", want.rb, got.rb);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("mecanum_wheel_mixer verification failed");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type row;
      int phase, n;
      // strafe, drive, turn, typed, {lf, lb, rf, rb}; reset registers apply
      directed_rows = '{
         '{8'd128, 8'd128, 8'd128, 1'b1, '{9'sd0, 9'sd0, 9'sd0, 9'sd0}},
         '{8'd128, 8'd255, 8'd128, 1'b1, '{9'sd255, 9'sd255, 9'sd255, 9'sd255}},
         '{8'd128, 8'd0, 8'd128, 1'b1, '{-9'sd255, -9'sd255, -9'sd255, -9'sd255}},
         '{8'd255, 8'd128, 8'd128, 1'b1, '{9'sd255, -9'sd255, -9'sd255, 9'sd255}},
         '{8'd0, 8'd128, 8'd128, 1'b1, '{-9'sd255, 9'sd255, 9'sd255, -9'sd255}},
         '{8'd128, 8'd128, 8'd255, 1'b1, '{9'sd255, 9'sd255, -9'sd255, -9'sd255}},
         '{8'd128, 8'd128, 8'd0, 1'b1, '{-9'sd255, -9'sd255, 9'sd255, 9'sd255}},
         // every axis inside the deadband
         '{8'd140, 8'd116, 8'd147, 1'b1, '{9'sd0, 9'sd0, 9'sd0, 9'sd0}},
         '{8'd147, 8'd109, 8'd128, 1'b1, '{9'sd0, 9'sd0, 9'sd0, 9'sd0}},
         // right on the deadband edge, then the all-low and all-high corners
         '{8'd148, 8'd108, 8'd128, 1'b0, '0},
         '{8'd0, 8'd0, 8'd0, 1'b0, '0},
         '{8'd255, 8'd255, 8'd255, 1'b0, '0},
         // first row has sums under 127, so the divisor stays at its floor; the rest raise it
         '{8'd158, 8'd158, 8'd158, 1'b0, '0},
         '{8'd255, 8'd255, 8'd128, 1'b0, '0},
         '{8'd0, 8'd255, 8'd255, 1'b0, '0},
         '{8'd1, 8'd254, 8'd127, 1'b0, '0}
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) offer_sample(directed_rows[i]);

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         req_valid <= 1'b0;
         wait_drained();
         set_config(phase_zone[phase], phase_speed[phase]);
         calm = (phase == NUM_PHASES - 1);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // long result-side hold while beats keep coming: fills the queue
            if (phase == 1 && n == 40) hold_request = 1'b1;
            if (phase == 5 && n == 80) begin
               req_valid <= 1'b0;
               wait_drained();
            end
            row = '{rand_axis(), rand_axis(), rand_axis(), 1'b0, '0};
            offer_sample(row);
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && pending_speeds.size() == 0)
         $display("mecanum_wheel_mixer verification clean");
      else
         $display("mecanum_wheel_mixer verification failed");
      $finish;
   end

endmodule
